/* rtl/positional_list_engine_unit_defines.svh */
// Assertion macros used by the checker file of the list engine.
`ifndef POSITIONAL_LIST_ENGINE_UNIT_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define PLE_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("list engine check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define PLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("list engine check failed");

`endif

/* rtl/ple_pkg.sv */
// Shared types, widths and codes of the positional list engine.
package ple_pkg;

  localparam int DATA_W       = 32;
  localparam int CMD_W        = 3;
  localparam int POS_W        = 5;
  localparam int ST_W         = 2;
  localparam int DEF_CAPACITY = 16;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_APPEND   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_POS  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INS_HEAD = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DEL_POS  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DEL_HEAD = 3'd5;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_BADIDX = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd3;

  // Per-cycle control broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;
    logic del;
    logic rot;
  } ctl_t;

endpackage

/* rtl/ple_cell.sv */
// One storage cell of the list chain: holds the element at a fixed index.
module ple_cell #(
  parameter int LEN_W = 5,
  parameter int CMP_W = 5,
  parameter int INDEX = 0
) (
  input  logic                        clk,
  input  ple_pkg::ctl_t               ctl,
  input  logic [CMP_W-1:0]            edit_idx,
  input  logic [LEN_W-1:0]            len_last,
  input  logic [ple_pkg::DATA_W-1:0]  value,
  input  logic [ple_pkg::DATA_W-1:0]  left,
  input  logic [ple_pkg::DATA_W-1:0]  right,
  input  logic [ple_pkg::DATA_W-1:0]  head,
  output logic [ple_pkg::DATA_W-1:0]  entry
);
  import ple_pkg::*;

  localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(INDEX);
  localparam logic [LEN_W-1:0] MY_POS = LEN_W'(INDEX);

  logic [DATA_W-1:0] entry_next;

  // Insert shifts up from the left, delete and rotate shift down from the right.
  always_comb begin
    entry_next = entry;
    if (ctl.ins) begin
      if (MY_IDX > edit_idx) begin
        entry_next = left;
      end else if (MY_IDX == edit_idx) begin
        entry_next = value;
      end
    end else if (ctl.del) begin
      if (MY_IDX >= edit_idx) begin
        entry_next = right;
      end
    end else if (ctl.rot) begin
      // The last occupied cell takes the head so the list wraps around.
      entry_next = (MY_POS == len_last) ? head : right;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

/* rtl/positional_list_engine_unit.sv */
// Edits: the single status beat appears on the cycle after start is taken.
// Read-out: busy while it runs, one element beat per cycle from the head, produced by
// rotating the cell chain once around the occupied cells; an empty list gives one empty status beat.
// Commands that are not edits or read-outs are taken without a result beat.
// Synchronous reset empties the list and clears control; stored elements are not cleared.
// Results cannot be stalled by the receiver; strobe marks each beat for one cycle.
module positional_list_engine_unit #(
  parameter int CAPACITY = ple_pkg::DEF_CAPACITY
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [ple_pkg::CMD_W-1:0]    command,
  input  logic [ple_pkg::POS_W-1:0]    position,
  input  logic signed [ple_pkg::DATA_W-1:0] value,
  output logic signed [ple_pkg::DATA_W-1:0] data,
  output logic [ple_pkg::ST_W-1:0]     status,
  output logic                         last,
  output logic                         strobe
);
  import ple_pkg::*;

  localparam int LEN_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (LEN_W > POS_W) ? LEN_W : POS_W;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic [0:0]        state;
  logic [LEN_W-1:0]  len;
  logic [LEN_W-1:0]  len_next;
  logic [LEN_W-1:0]  cnt;
  logic [LEN_W-1:0]  len_last;
  logic [CMP_W-1:0]  len_ext;
  logic [CMP_W-1:0]  pos_ext;
  logic [CMP_W-1:0]  edit_idx;
  logic              accept;
  logic              res_valid;
  logic [ST_W-1:0]   res_status;
  logic              go_read;
  ctl_t              ctl;
  logic [DATA_W-1:0] ent [CAPACITY];

  assign busy     = (state == S_READ);
  assign accept   = start & ~busy;
  assign len_last = len - LEN_W'(1);
  assign len_ext  = CMP_W'(len);
  assign pos_ext  = CMP_W'(position);

  // Command decode: status checks and chain control for the accepted beat.
  always_comb begin
    ctl        = '0;
    edit_idx   = pos_ext;
    res_valid  = 1'b0;
    res_status = ST_OK;
    go_read    = 1'b0;
    len_next   = len;
    if (state == S_READ) begin
      ctl.rot = 1'b1;
    end else if (accept) begin
      case (command)
        CMD_APPEND, CMD_INS_POS, CMD_INS_HEAD: begin
          if (command == CMD_APPEND) begin
            edit_idx = len_ext;
          end else if (command == CMD_INS_HEAD) begin
            edit_idx = '0;
          end
          res_valid = 1'b1;
          if (len >= LEN_W'(CAPACITY)) begin
            res_status = ST_FULL;
          end else if (edit_idx > len_ext) begin
            res_status = ST_BADIDX;
          end else begin
            ctl.ins  = 1'b1;
            len_next = len + LEN_W'(1);
          end
        end
        CMD_DEL_POS, CMD_DEL_HEAD: begin
          if (command == CMD_DEL_HEAD) begin
            edit_idx = '0;
          end
          res_valid = 1'b1;
          if (len == '0) begin
            res_status = ST_EMPTY;
          end else if (edit_idx >= len_ext) begin
            res_status = ST_BADIDX;
          end else begin
            ctl.del  = 1'b1;
            len_next = len - LEN_W'(1);
          end
        end
        CMD_READ: begin
          if (len == '0) begin
            res_valid  = 1'b1;
            res_status = ST_EMPTY;
          end else begin
            go_read = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Chain of cells; each neighbor link is a fixed wire.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_in;
    logic [DATA_W-1:0] right_in;
    if (i == 0) begin : g_first
      assign left_in = value;
    end else begin : g_mid_l
      assign left_in = ent[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign right_in = ent[i];
    end else begin : g_mid_r
      assign right_in = ent[i+1];
    end
    ple_cell #(
      .LEN_W (LEN_W),
      .CMP_W (CMP_W),
      .INDEX (i)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .edit_idx (edit_idx),
      .len_last (len_last),
      .value    (value),
      .left     (left_in),
      .right    (right_in),
      .head     (ent[0]),
      .entry    (ent[i])
    );
  end

  // Control state and control outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      len    <= '0;
      cnt    <= '0;
      strobe <= 1'b0;
      last   <= 1'b0;
    end else if (state == S_READ) begin
      strobe <= 1'b1;
      last   <= (cnt == len_last);
      cnt    <= cnt + LEN_W'(1);
      if (cnt == len_last) begin
        state <= S_IDLE;
      end
    end else begin
      len    <= len_next;
      strobe <= res_valid;
      last   <= res_valid;
      if (go_read) begin
        state <= S_READ;
        cnt   <= '0;
      end
    end
  end

  // Result payload: the head element during read-out, zero with a status otherwise.
  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      data   <= ent[0];
      status <= ST_OK;
    end else begin
      data   <= '0;
      status <= res_status;
    end
  end

endmodule

/* rtl/ple_checker.sv */
// Port-level checker for the list engine and its bind to the top level.
`include "positional_list_engine_unit_defines.svh"

module ple_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic [ple_pkg::DATA_W-1:0]  data,
  input logic [ple_pkg::ST_W-1:0]    status,
  input logic                        last,
  input logic                        strobe
);
  import ple_pkg::*;

  // A read-out beat that is not the final one always carries ok status.
  `PLE_ASSERT_NOW(a_mid_ok, clk, rst, strobe && !last, status == ST_OK)
  // Error beats carry zero data.
  `PLE_ASSERT_NOW(a_err_zero, clk, rst, strobe && status != ST_OK, data == '0)
  // The final mark only appears on a result beat.
  `PLE_ASSERT_NOW(a_last_strobe, clk, rst, last, strobe)
  // A read-out does not stop before its final beat.
  `PLE_ASSERT_NEXT(a_read_cont, clk, rst, strobe && !last, strobe)
  // The engine only turns busy after taking a start.
  `PLE_ASSERT_NOW(a_busy_start, clk, rst, $rose(busy), $past(start))

endmodule

bind positional_list_engine_unit ple_checker u_ple_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .data   (data),
  .status (status),
  .last   (last),
  .strobe (strobe)
);

/* tb/sv/tb_positional_list_engine_unit.sv */
// Self-checking testbench of the positional list engine: a mirror list predicts every beat.
`timescale 1ns / 1ps

module tb_positional_list_engine_unit;
  import ple_pkg::*;

  localparam int CAPACITY = DEF_CAPACITY;
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
  localparam int NUM_ITEMS = 420;
  localparam int DRAIN_LIMIT = 5000;

  typedef struct {
    logic signed [DATA_W-1:0] data;
    logic [ST_W-1:0] status;
    logic last;
  } list_beat_t;

  // Mirror of the list contents; turns accepted commands into expected beats.
  class list_mirror;
    logic signed [DATA_W-1:0] cells[CAPACITY];
    int length;
    list_beat_t owed_beats[$];
    int errors;

    function new();
      length = 0;
      errors = 0;
    endfunction

    function void push_beat(logic signed [DATA_W-1:0] d, logic [ST_W-1:0] st, logic lst);
      list_beat_t b;
      b.data = d;
      b.status = st;
      b.last = lst;
      owed_beats.push_back(b);
    endfunction

    function logic [ST_W-1:0] insert_at(int idx, logic signed [DATA_W-1:0] val);
      if (length >= CAPACITY) return ST_FULL;
      if (idx > length) return ST_BADIDX;
      for (int i = length; i > idx; i--) cells[i] = cells[i-1];
      cells[idx] = val;
      length++;
      return ST_OK;
    endfunction

    function logic [ST_W-1:0] delete_at(int idx);
      if (length == 0) return ST_EMPTY;
      if (idx >= length) return ST_BADIDX;
      for (int i = idx; i < length - 1; i++) cells[i] = cells[i+1];
      length--;
      return ST_OK;
    endfunction

    // Note one accepted command and queue the beats it must produce.
    function void note_command(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                               logic signed [DATA_W-1:0] val);
      case (cmd)
        CMD_APPEND:   push_beat('0, insert_at(length, val), 1'b1);
        CMD_INS_POS:  push_beat('0, insert_at(int'(pos), val), 1'b1);
        CMD_INS_HEAD: push_beat('0, insert_at(0, val), 1'b1);
        CMD_READ: begin
          if (length == 0) begin
            push_beat('0, ST_EMPTY, 1'b1);
          end else begin
            for (int i = 0; i < length; i++) push_beat(cells[i], ST_OK, i == length - 1);
          end
        end
        CMD_DEL_POS:  push_beat('0, delete_at(int'(pos)), 1'b1);
        CMD_DEL_HEAD: push_beat('0, delete_at(0), 1'b1);
        default: ;
      endcase
    endfunction

    function void report(string what);
      errors++;
      if (errors <= 10) $display("MISMATCH: %s", what);
    endfunction

    // Compare one observed beat with the oldest owed beat.
    function void check_beat(logic signed [DATA_W-1:0] d, logic [ST_W-1:0] st, logic lst);
      list_beat_t want;
      if (owed_beats.size() == 0) begin
        report($sformatf("unexpected beat data=%0d status=%0d last=%0b", d, st, lst));
        return;
      end
      want = owed_beats.pop_front();
      if (d !== want.data)
        report($sformatf("data expected %0d got %0d", want.data, d));
      if (st !== want.status)
        report($sformatf("status expected %0d got %0d", want.status, st));
      if (lst !== want.last)
        report($sformatf("last expected %0b got %0b", want.last, lst));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic [CMD_W-1:0] command;
  logic [POS_W-1:0] position;
  logic signed [DATA_W-1:0] value;
  logic signed [DATA_W-1:0] data;
  logic [ST_W-1:0] status;
  logic last;
  logic strobe;

  list_mirror mirror = new();

  positional_list_engine_unit #(.CAPACITY(CAPACITY)) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .position(position),
    .value(value),
    .data(data),
    .status(status),
    .last(last),
    .strobe(strobe)
  );

  always #2 clk = ~clk;

  // Every strobed beat is checked at the edge that ends its cycle.
  always @(posedge clk) begin
    if (!rst && strobe) mirror.check_beat(data, status, last);
  end

  // Present one command and hold it until the block takes it.
  task automatic issue(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                       logic signed [DATA_W-1:0] val);
    start <= 1'b1;
    command <= cmd;
    position <= pos;
    value <= val;
    do @(posedge clk); while (busy);
    mirror.note_command(cmd, pos, val);
  endtask

  task automatic rest(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Hold off the sender until every owed beat has come back.
  task automatic drain();
    int waited;
    waited = 0;
    rest(2);
    while (mirror.owed_beats.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return -32'sd1;
      3: return 32'sd0;
      default: return $urandom();
    endcase
  endfunction

  // Mostly in-range positions, sometimes any position from 0 to 16.
  function automatic logic [POS_W-1:0] pick_position(int top);
    if (top >= 0 && $urandom_range(0, 9) < 8) return POS_W'($urandom_range(0, top));
    return POS_W'($urandom_range(0, 16));
  endfunction

  // Draw one command, weighted by the current phase: grow, shrink or mixed.
  task automatic random_command(int phase);
    int r;
    int len;
    logic [CMD_W-1:0] cmd;
    r = $urandom_range(0, 99);
    len = mirror.length;
    case (phase)
      0: cmd = (r < 40) ? CMD_APPEND : (r < 65) ? CMD_INS_POS : (r < 80) ? CMD_INS_HEAD :
               (r < 88) ? CMD_READ : (r < 93) ? CMD_DEL_POS : (r < 97) ? CMD_DEL_HEAD :
               (r < 99) ? CMD_SPARE_LO : CMD_SPARE_HI;
      1: cmd = (r < 40) ? CMD_DEL_POS : (r < 70) ? CMD_DEL_HEAD : (r < 82) ? CMD_READ :
               (r < 88) ? CMD_APPEND : (r < 94) ? CMD_INS_POS : (r < 98) ? CMD_INS_HEAD :
               CMD_SPARE_HI;
      default: cmd = (r < 18) ? CMD_APPEND : (r < 36) ? CMD_INS_POS : (r < 48) ? CMD_INS_HEAD :
                     (r < 62) ? CMD_READ : (r < 80) ? CMD_DEL_POS : (r < 96) ? CMD_DEL_HEAD :
                     (r < 98) ? CMD_SPARE_LO : CMD_SPARE_HI;
    endcase
    if (cmd == CMD_DEL_POS) issue(cmd, pick_position(len - 1), pick_value());
    else issue(cmd, pick_position(len), pick_value());
  endtask

  // Overall time limit.
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int done_items;
    int burst;
    int phase;
    int waited;
    rst <= 1'b1;
    start <= 1'b0;
    command <= CMD_APPEND;
    position <= '0;
    value <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners: empty list, bad indexes, extremes of value, spare codes.
    issue(CMD_READ, 5'd0, 32'sd0);
    issue(CMD_DEL_HEAD, 5'd0, 32'sd0);
    issue(CMD_DEL_POS, 5'd16, 32'sd0);
    issue(CMD_INS_POS, 5'd3, 32'sd5);
    issue(CMD_INS_POS, 5'd0, 32'sd0);
    issue(CMD_APPEND, 5'd0, 32'sh7FFF_FFFF);
    issue(CMD_INS_HEAD, 5'd0, 32'sh8000_0000);
    issue(CMD_INS_POS, 5'd3, -32'sd1);
    issue(CMD_INS_POS, 5'd5, 32'sh5555_5555);
    issue(CMD_INS_POS, 5'd16, 32'shAAAA_AAAA);
    issue(CMD_DEL_POS, 5'd4, 32'sd0);
    issue(CMD_DEL_POS, 5'd16, 32'sd0);
    issue(CMD_READ, 5'd0, 32'sd0);
    issue(CMD_SPARE_LO, 5'd1, 32'sd7);
    issue(CMD_SPARE_HI, 5'd31, -32'sd7);
    issue(CMD_DEL_POS, 5'd1, 32'sd0);
    issue(CMD_DEL_HEAD, 5'd0, 32'sd0);
    issue(CMD_READ, 5'd0, 32'sd0);
    drain();

    // Random bursts with random gaps; the phase is drawn anew every 24 items.
    done_items = 0;
    phase = 0;
    while (done_items < NUM_ITEMS) begin
      burst = $urandom_range(1, 16);
      for (int i = 0; i < burst && done_items < NUM_ITEMS; i++) begin
        if (done_items % 24 == 0 && done_items != 0) phase = $urandom_range(0, 2);
        random_command(phase);
        done_items++;
        if (done_items == NUM_ITEMS / 2) drain();
      end
      if ($urandom_range(0, 3) != 0) rest($urandom_range(1, 6));
    end

    // Let the last beats arrive, then watch for strays.
    rest(1);
    waited = 0;
    while (mirror.owed_beats.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (CAPACITY + 8) @(posedge clk);
    if (mirror.owed_beats.size() != 0)
      mirror.report($sformatf("%0d beats never arrived", mirror.owed_beats.size()));

    if (mirror.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
